### hw/rtl/cls_pkg.sv
`default_nettype none
package cls_pkg;

	localparam int PIX_W = 8;
	localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

	// Item kinds
	localparam logic KIND_MEASURE = 1'b0;
	localparam logic KIND_STRETCH = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	// Input request
	typedef struct packed {
		logic kind;
		pix_t pixel;
		logic start_req;
		logic frame_end;
	} cls_in_t;

	// Result request
	typedef struct packed {
		pix_t pixel_out;
		logic end_out;
	} cls_out_t;

	// Stretch job: pixel plus the min/max snapshot it must use
	typedef struct packed {
		pix_t pixel;
		pix_t low;
		pix_t high;
		logic frame_end;
	} cls_job_t;

	// Queue status toward the back end
	typedef struct packed {
		logic     empty;
		cls_job_t head;
	} cls_qstat_t;

endpackage
`default_nettype wire

### hw/rtl/cls_stream_if.sv
`default_nettype none
interface cls_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/contrast_linear_stretch_top.sv
// Linear contrast stretch of 8-bit grey pixels, image fed twice. Measure
// requests (kind 0) update a running min/max and return nothing; start_req
// reloads both from the pixel. Stretch requests (kind 1) return one pixel:
// (pixel-min)*255/(max-min) truncated toward zero and clamped to 0..255, or
// the pixel itself when min equals max; frame_end comes back as end_out.
// Measure requests are taken one per clock whenever the job queue has room.
// Stretch requests queue up with a snapshot of min/max; the back end
// takes one job at a time: a setup step as it pops the job, then its
// restoring divider (one quotient bit a cycle), then a load of the
// output register once the last result is taken; fixed answers (flat
// image, clamp to 0, or clamp to 255) skip the divide. The divider sets
// the stretch-pass rate. After reset min is 255 and max is 0.
`default_nettype none
module contrast_linear_stretch_top #(
	parameter int QUEUE_DEPTH = 4  // job queue entries, 2 or more
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	cls_stream_if.sink   sample,
	cls_stream_if.source result
);
	import cls_pkg::*;

	// Front end -> queue
	logic       push;
	cls_job_t   push_job;
	logic       q_full;
	// Queue -> back end
	cls_qstat_t q_stat;
	logic       pop;
	// Back end output
	logic       res_valid;
	cls_out_t   res_data;

	// Front: accept, classify, track min/max
	cls_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_data  (sample.data),
		.in_ready (sample.ready),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// Decoupling queue so front and back stall independently
	cls_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.stat     (q_stat)
	);

	// Back: divide, clamp, registered result
	cls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (q_stat),
		.pop       (pop),
		.out_valid (res_valid),
		.out_ready (result.ready),
		.out_data  (res_data)
	);

	assign result.valid = res_valid;
	assign result.data  = res_data;
endmodule
`default_nettype wire

### hw/rtl/cls_front.sv
`default_nettype none
// Takes requests, tracks running min/max, forwards stretch jobs.
module cls_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire cls_pkg::cls_in_t in_data,
	output logic                  in_ready,
	input  wire logic             q_full,
	output logic                  push,
	output cls_pkg::cls_job_t     push_job
);
	import cls_pkg::*;

	pix_t low_q;
	pix_t high_q;
	logic accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (in_data.kind == KIND_STRETCH);

	assign push_job.pixel     = in_data.pixel;
	assign push_job.low       = low_q;
	assign push_job.high      = high_q;
	assign push_job.frame_end = in_data.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= FULL_SCALE;
			high_q <= '0;
		end else if (accept && (in_data.kind == KIND_MEASURE)) begin
			if (in_data.start_req) begin
				low_q  <= in_data.pixel;
				high_q <= in_data.pixel;
			end else begin
				if (in_data.pixel < low_q)  low_q  <= in_data.pixel;
				if (in_data.pixel > high_q) high_q <= in_data.pixel;
			end
		end
	end
endmodule
`default_nettype wire

### hw/rtl/cls_queue.sv
`default_nettype none
// Small job FIFO between front and back; head is shown combinationally.
module cls_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire cls_pkg::cls_job_t push_job,
	output logic                   full,
	input  wire logic              pop,
	output cls_pkg::cls_qstat_t    stat
);
	import cls_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cls_job_t             entry_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.head  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && !stat.empty;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

### hw/rtl/cls_back.sv
`default_nettype none
// Stretch engine: setup cycle, 8-step restoring divide (skipped for fixed answers), output register.
module cls_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cls_pkg::cls_qstat_t stat,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output cls_pkg::cls_out_t        out_data
);
	import cls_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;
	localparam int   QSTEPS  = PIX_W;
	localparam int   CNT_W   = $clog2(QSTEPS + 1);
	localparam int   NUM_W   = 2 * PIX_W;

	logic                  state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [NUM_W-1:0]      rem_q;
	logic [NUM_W-2:0]      dsh_q;
	pix_t                  quot_q;
	logic                  end_q;
	logic                  out_valid_q;
	cls_out_t              out_q;

	// Setup math on the queue head
	logic [PIX_W:0]        diff;
	logic [PIX_W:0]        rng;
	pix_t                  dmag;
	pix_t                  rmag;
	logic [NUM_W-1:0]      num;
	logic                  flat;
	logic                  neg;
	logic                  sat;
	// Iteration
	logic                  ge;
	logic                  out_free;
	logic                  finish;

	assign diff = {1'b0, stat.head.pixel} - {1'b0, stat.head.low};
	assign rng  = {1'b0, stat.head.high} - {1'b0, stat.head.low};
	assign dmag = diff[PIX_W] ? PIX_W'(-diff) : diff[PIX_W-1:0];
	assign rmag = rng[PIX_W] ? PIX_W'(-rng) : rng[PIX_W-1:0];
	// |diff| * 255 as shift and subtract
	assign num  = {dmag, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, dmag};
	assign flat = (stat.head.low == stat.head.high);
	assign neg  = diff[PIX_W] ^ rng[PIX_W];
	assign sat  = (num >= {rmag, {PIX_W{1'b0}}});

	assign ge       = ({1'b0, dsh_q} <= rem_q);
	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == ST_RUN) && (cnt_q == '0) && out_free;
	assign pop      = (state_q == ST_IDLE) && !stat.empty;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			end_q <= stat.head.frame_end;
			rem_q <= num;
			dsh_q <= (NUM_W-1)'({rmag, {(PIX_W-1){1'b0}}});
			if (flat) begin
				quot_q <= stat.head.pixel;
			end else if (neg || (dmag == '0)) begin
				quot_q <= '0;
			end else if (sat) begin
				quot_q <= FULL_SCALE;
			end else begin
				quot_q <= '0;
			end
		end else if ((state_q == ST_RUN) && (cnt_q != '0)) begin
			if (ge) rem_q <= rem_q - {1'b0, dsh_q};
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[PIX_W-2:0], ge};
		end
		if (finish) begin
			out_q.pixel_out <= quot_q;
			out_q.end_out   <= end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_RUN;
						// fixed answers skip the divide
						cnt_q   <= (flat || neg || (dmag == '0) || sat) ?
							'0 : CNT_W'(QSTEPS);
					end
				end
				ST_RUN: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (finish)         out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

### hw/rtl/cls_checker.sv
`default_nettype none
module cls_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              sample_valid,
	input wire logic              sample_ready,
	input wire cls_pkg::cls_in_t  sample_data,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire cls_pkg::cls_out_t result_data
);
	import cls_pkg::*;

	// Result held until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_data))
		else $error("result payload changed while stalled");

	// No result out of reset: a clock seen in reset leaves valid low
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result valid during reset");

	// Back-pressure only appears right after a stretch request was queued
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sample_ready) |->
			$past(sample_valid && sample_ready && (sample_data.kind == KIND_STRETCH)))
		else $error("input stalled without a queued stretch request");
endmodule

bind contrast_linear_stretch_top cls_checker u_cls_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.sample_data  (sample.data),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);
`default_nettype wire
